/* rtl/core/assert_macros.svh */
// Assertion macros shared by the decoder's checking code.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CHK_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define CHK_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bpd_pkg.sv */
// Shared types and constants of the bitmap pixel row decoder.
// No dependencies; imported by every module of the block but bpd_ram.
package bpd_pkg;

	localparam int MAX_WIDTH     = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int Q_DEPTH       = 4;

	// configuration register indexes
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// pixel formats
	localparam logic [1:0] FMT_RGB24 = 2'd0;
	localparam logic [1:0] FMT_PAL8  = 2'd1;
	localparam logic [1:0] FMT_PAL4  = 2'd2;
	localparam logic [1:0] FMT_NONE  = 2'd3;

	// queue entry operations
	localparam logic [1:0] OP_PAL_WR = 2'd0;
	localparam logic [1:0] OP_RGB    = 2'd1;
	localparam logic [1:0] OP_LUT    = 2'd2;

	typedef struct packed {
		logic [1:0]  fmt;
		logic [12:0] width;
		logic [12:0] height;
	} bpd_cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        two_pix;  // lookup entry carries a second pixel
		logic [7:0]  idx_a;    // palette index, first pixel or palette write
		logic [7:0]  idx_b;
		logic [23:0] rgb;      // {red, green, blue}
		logic [11:0] col;      // column of the first pixel
		logic [11:0] row;
		logic        done_a;
		logic        done_b;
	} bpd_entry_t;

	typedef struct packed {
		logic        we;
		logic [7:0]  waddr;
		logic [23:0] wdata;
		logic        re;
		logic [7:0]  raddr;
	} bpd_ram_req_t;

endpackage

/* rtl/core/bpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module bpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/bpd_queue.sv */
// Short queue of decoded operations between front and back.
// Depends on bpd_pkg for the entry type and depth.
module bpd_queue import bpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  bpd_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output bpd_entry_t head,
	output logic       empty,
	output logic [$clog2(Q_DEPTH):0] count
);

	localparam int PW = $clog2(Q_DEPTH);

	bpd_entry_t    ent_q [Q_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full    = (count_q == (PW+1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_ptr_q];
	assign count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

/* rtl/core/bpd_front.sv */
// Front end: accepts words, tracks row, column, padding and byte gathering,
// and queues palette writes and pixel operations. Depends on bpd_pkg.
module bpd_front import bpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  bpd_cfg_t   cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       req_type,
	input  logic [7:0] data_byte,
	input  logic [7:0] pal_index,
	input  logic [23:0] pal_rgb,
	input  logic       q_full,
	output logic       push,
	output bpd_entry_t push_entry
);

	logic [1:0]  phase_q, phase_n;
	logic [7:0]  held1_q, held1_n;
	logic [7:0]  held2_q, held2_n;
	logic [12:0] col_q, col_n;
	logic [12:0] row_q, row_n;
	logic [1:0]  rbp_q, rbp_n;
	logic [1:0]  pad_q, pad_n;

	logic [12:0] eff_w;
	logic [12:0] eff_h;
	logic        accept;
	logic        pixel_act;
	logic        emit;
	logic        second;
	logic [1:0]  col_inc;
	logic [13:0] col_new;
	logic [1:0]  pad;
	logic        row_last;

	always_comb begin
		priority if (cfg.width == '0) begin
			eff_w = 13'd1;
		end else if (32'(cfg.width) > MAX_WIDTH) begin
			eff_w = 13'(MAX_WIDTH);
		end else begin
			eff_w = cfg.width;
		end
		priority if (cfg.height == '0) begin
			eff_h = 13'd1;
		end else if (32'(cfg.height) > MAX_HEIGHT) begin
			eff_h = 13'(MAX_HEIGHT);
		end else begin
			eff_h = cfg.height;
		end
	end

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign pixel_act = accept && !req_type && (cfg.fmt != FMT_NONE) && (row_q < eff_h);
	assign row_last  = (row_q == eff_h - 13'd1);

	always_comb begin
		phase_n = phase_q;
		held1_n = held1_q;
		held2_n = held2_q;
		col_n   = col_q;
		row_n   = row_q;
		rbp_n   = rbp_q;
		pad_n   = pad_q;
		emit    = 1'b0;
		second  = 1'b0;
		col_inc = 2'd0;
		col_new = '0;
		pad     = '0;
		push_entry         = '0;
		push_entry.col     = col_q[11:0];
		push_entry.row     = row_q[11:0];
		push_entry.done_a  = (col_q == eff_w - 13'd1) && row_last;
		push_entry.done_b  = (14'(col_q) + 14'd1 == 14'(eff_w) - 14'd1) && row_last;

		if (accept && req_type) begin
			push_entry.op    = OP_PAL_WR;
			push_entry.idx_a = pal_index;
			push_entry.rgb   = pal_rgb;
		end else if (pixel_act) begin
			if (pad_q != 2'd0) begin
				pad_n = pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					row_n = row_q + 13'd1;
					rbp_n = 2'd0;
				end
			end else begin
				rbp_n = rbp_q + 2'd1;
				unique case (cfg.fmt)
					FMT_RGB24: begin
						priority if (phase_q == 2'd0) begin
							held1_n = data_byte;
							phase_n = 2'd1;
						end else if (phase_q == 2'd1) begin
							held2_n = data_byte;
							phase_n = 2'd2;
						end else begin
							phase_n        = 2'd0;
							emit           = 1'b1;
							col_inc        = 2'd1;
							push_entry.op  = OP_RGB;
							push_entry.rgb = {data_byte, held2_q, held1_q};
						end
					end
					FMT_PAL8: begin
						emit             = 1'b1;
						col_inc          = 2'd1;
						push_entry.op    = OP_LUT;
						push_entry.idx_a = data_byte;
					end
					FMT_PAL4: begin
						// low nibble only when its column is inside the row
						second             = (14'(col_q) + 14'd1) < 14'(eff_w);
						emit               = 1'b1;
						col_inc            = second ? 2'd2 : 2'd1;
						push_entry.op      = OP_LUT;
						push_entry.two_pix = second;
						push_entry.idx_a   = {4'd0, data_byte[7:4]};
						push_entry.idx_b   = {4'd0, data_byte[3:0]};
					end
					default: begin
					end
				endcase
				if (emit) begin
					col_new = 14'(col_q) + 14'(col_inc);
					if (col_new >= 14'(eff_w)) begin
						col_n   = '0;
						phase_n = 2'd0;
						pad     = 2'd0 - rbp_n;
						if (pad == 2'd0) begin
							row_n = row_q + 13'd1;
							rbp_n = 2'd0;
							pad_n = 2'd0;
						end else begin
							pad_n = pad;
						end
					end else begin
						col_n = col_new[12:0];
					end
				end
			end
		end
	end

	assign push = accept && (req_type || emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			held1_q <= '0;
			held2_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
			rbp_q   <= '0;
			pad_q   <= '0;
		end else begin
			phase_q <= phase_n;
			held1_q <= held1_n;
			held2_q <= held2_n;
			col_q   <= col_n;
			row_q   <= row_n;
			rbp_q   <= rbp_n;
			pad_q   <= pad_n;
		end
	end

endmodule

/* rtl/core/bpd_back.sv */
// Back end: runs queued operations, drives the palette RAM and holds the
// output word. Depends on bpd_pkg; the RAM itself sits in the top level.
module bpd_back import bpd_pkg::*; #(
	parameter int DEPTH = PALETTE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  bpd_entry_t   head,
	input  logic         q_empty,
	output logic         pop,
	output bpd_ram_req_t ram_req,
	input  logic [23:0]  ram_rdata,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [23:0]  out_rgb,
	output logic [11:0]  out_col,
	output logic [11:0]  out_row,
	output logic         out_last,
	output logic         out_done
);

	logic        half_q, half_n;
	logic        valid_s2;
	logic        from_ram_s2;
	logic        hit_s2;
	logic [23:0] rgb_s2;
	logic [11:0] col_s2;
	logic [11:0] row_s2;
	logic        last_s2;
	logic        done_s2;

	logic        adv;
	logic        load;
	logic        ld_from_ram;
	logic        ld_hit;
	logic [11:0] ld_col;
	logic        ld_last;
	logic        ld_done;
	logic [7:0]  rd_idx;

	assign adv = !valid_s2 || out_ready;

	always_comb begin
		pop         = 1'b0;
		half_n      = half_q;
		load        = 1'b0;
		ld_from_ram = 1'b0;
		ld_hit      = 1'b0;
		ld_col      = head.col;
		ld_last     = 1'b1;
		ld_done     = head.done_a;
		rd_idx      = half_q ? head.idx_b : head.idx_a;
		ram_req       = '0;
		ram_req.waddr = head.idx_a;
		ram_req.wdata = head.rgb;
		ram_req.raddr = rd_idx;
		if (!q_empty) begin
			unique case (head.op)
				OP_PAL_WR: begin
					// writes beyond the palette are dropped
					ram_req.we = (9'(head.idx_a) < 9'(DEPTH));
					pop        = 1'b1;
				end
				OP_RGB: begin
					if (adv) begin
						load = 1'b1;
						pop  = 1'b1;
					end
				end
				OP_LUT: begin
					if (adv) begin
						load        = 1'b1;
						ld_from_ram = 1'b1;
						ld_hit      = (9'(rd_idx) < 9'(DEPTH));
						ram_req.re  = ld_hit;
						if (half_q) begin
							ld_col  = head.col + 12'd1;
							ld_done = head.done_b;
						end else begin
							ld_last = !head.two_pix;
						end
						if (head.two_pix && !half_q) begin
							half_n = 1'b1;
						end else begin
							half_n = 1'b0;
							pop    = 1'b1;
						end
					end
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			half_q <= half_n;
			if (adv) begin
				valid_s2 <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && load) begin
			from_ram_s2 <= ld_from_ram;
			hit_s2      <= ld_hit;
			rgb_s2      <= head.rgb;
			col_s2      <= ld_col;
			row_s2      <= head.row;
			last_s2     <= ld_last;
			done_s2     <= ld_done;
		end
	end

	// RAM read data stays put while no new read is issued
	assign out_valid = valid_s2;
	assign out_rgb   = from_ram_s2 ? (hit_s2 ? ram_rdata : 24'd0) : rgb_s2;
	assign out_col   = col_s2;
	assign out_row   = row_s2;
	assign out_last  = last_s2;
	assign out_done  = done_s2;

endmodule

/* rtl/core/bitmap_pixel_row_decoder_top.sv */
// Top level of the bitmap pixel row decoder: config registers, front end,
// queue, back end and palette RAM. Depends on bpd_pkg and assert_macros.svh.
//
// channel | dir | handshake                      | payload
// s_axis  | in  | s_axis_tvalid / s_axis_tready  | tdata: byte, pal index, r, g, b
// m_axis  | out | m_axis_tvalid / m_axis_tready  | tdata: r, g, b, column, row
// cfg     | in  | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// One word per cycle in 24-bit and 8-bit modes while the queue is not full; a 4-bit byte
// giving two pixels holds the back end for two palette reads, on the single read port.
// An accepted byte is queued, then its output word and RAM read are registered on pop.
// Reset clears all counters and the queue; the palette is undefined until written.
// Output stalls back up through the four-entry queue into s_axis_tready.
`include "assert_macros.svh"

module bitmap_pixel_row_decoder_top import bpd_pkg::*; #(
	parameter int PAL_DEPTH = PALETTE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data_byte, palette_index, palette_red,
	                                   // palette_green, palette_blue
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // red, green, blue, pixel_column, pixel_row
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,  // image_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;

	bpd_cfg_t     cfg_q;
	logic         q_push;
	bpd_entry_t   q_in;
	logic         q_full;
	logic         q_pop;
	bpd_entry_t   q_head;
	logic         q_empty;
	logic [$clog2(Q_DEPTH):0] q_count;
	bpd_ram_req_t ram_req;
	logic [23:0]  ram_rdata;
	logic [23:0]  out_rgb;
	logic [11:0]  out_col;
	logic [11:0]  out_row;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt    <= FMT_RGB24;
			cfg_q.width  <= 13'd1;
			cfg_q.height <= 13'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FORMAT: cfg_q.fmt    <= cfg_data[1:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// palette entries are kept as {r,g,b}, red in the high byte
	bpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.req_type   (s_axis_tuser),
		.data_byte  (s_axis_tdata[7:0]),
		.pal_index  (s_axis_tdata[15:8]),
		.pal_rgb    ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_in)
	);

	bpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.count      (q_count)
	);

	bpd_back #(
		.DEPTH (PAL_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rgb   (out_rgb),
		.out_col   (out_col),
		.out_row   (out_row),
		.out_last  (m_axis_tlast),
		.out_done  (m_axis_tuser)
	);

	bpd_ram #(
		.WIDTH (24),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr[AW-1:0]),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	// stored {r,g,b} goes out red in the low byte
	assign m_axis_tdata = {out_row, out_col, out_rgb[7:0], out_rgb[15:8], out_rgb[23:16]};

	`CHK_ALWAYS(a_q_bound, q_count <= ($clog2(Q_DEPTH)+1)'(Q_DEPTH), "queue overflow")
	`CHK_ALWAYS(a_ram_one_op, !(ram_req.we && ram_req.re), "palette read and write together")
	`CHK_NEXT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[35:24] == $past(m_axis_tdata[35:24]) + 12'd1), "second nibble pixel missing")

endmodule
